>>> rtl/modbus_rtu_slave_register_server_core_macros.svh
// Assertion macros shared by the checker.
`ifndef MODBUS_RTU_SLAVE_REGISTER_SERVER_CORE_MACROS_SVH
`define MODBUS_RTU_SLAVE_REGISTER_SERVER_CORE_MACROS_SVH

// Same-cycle implication.
`define MBRTU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MBRTU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mbrtu_pkg.sv
`timescale 1ns / 1ps
package mbrtu_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int FB_AW       = 8;
    localparam int RESP_BYTES  = 256;
    localparam int REG_DEPTH   = 64;
    localparam int REG_AW      = 6;
    localparam int MAX_READ    = 125;
    localparam int MAX_WRITE   = 123;
    localparam int MIN_FRAME   = 8;
    localparam int HDR_BYTES   = 6;
    localparam int CFG_AW      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] FN_RD_HOLD   = 8'd3;
    localparam logic [7:0] FN_RD_INPUT  = 8'd4;
    localparam logic [7:0] FN_WR_SINGLE = 8'd6;
    localparam logic [7:0] FN_WR_MULTI  = 8'd16;

    localparam logic [7:0] EXC_FUNC  = 8'd1;
    localparam logic [7:0] EXC_ADDR  = 8'd2;
    localparam logic [7:0] EXC_VALUE = 8'd3;
    localparam logic [7:0] EXC_FLAG  = 8'h80;
    localparam logic [7:0] BCAST_ADDR = 8'h00;

    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_REPLY = 3'd1;
    localparam logic [2:0] ST_OTHER = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;

    localparam logic [2:0] REG_SLAVE     = 3'd0;
    localparam logic [2:0] REG_IN_BASE   = 3'd1;
    localparam logic [2:0] REG_IN_CNT    = 3'd2;
    localparam logic [2:0] REG_HOLD_BASE = 3'd3;
    localparam logic [2:0] REG_HOLD_CNT  = 3'd4;

    localparam logic [1:0] ACT_RX      = 2'd0;
    localparam logic [1:0] ACT_PULL    = 2'd1;
    localparam logic [1:0] ACT_HOST_WR = 2'd2;
    localparam logic [1:0] ACT_HOST_RD = 2'd3;

    typedef enum logic [1:0] {
        OP_RX      = 2'd0,
        OP_PULL    = 2'd1,
        OP_HOST_WR = 2'd2,
        OP_HOST_RD = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  rx_byte;
        logic        last;
        logic [5:0]  idx;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] input_base;
        logic [6:0]  input_count;
        logic [15:0] holding_base;
        logic [6:0]  holding_count;
    } t_cfg;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] host_data;
        logic [2:0]  frame_status;
    } t_res;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/mbrtu_if.sv
`timescale 1ns / 1ps
interface mbrtu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic        frame_last;
    logic [5:0]  host_index;
    logic [15:0] host_value;

    modport source (output valid, action, rx_byte, frame_last, host_index, host_value,
                    input ready);
    modport sink (input valid, action, rx_byte, frame_last, host_index, host_value,
                  output ready);
endinterface

interface mbrtu_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] host_data;
    logic [2:0]  frame_status;

    modport source (output valid, tx_valid, tx_byte, tx_last, host_data, frame_status,
                    input ready);
    modport sink (input valid, tx_valid, tx_byte, tx_last, host_data, frame_status,
                  output ready);
endinterface

>>> rtl/mbrtu_regs.sv
`timescale 1ns / 1ps
module mbrtu_regs import mbrtu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address <= 8'd1;
            r_cfg.input_base    <= 16'd0;
            r_cfg.input_count   <= 7'(REG_DEPTH);
            r_cfg.holding_base  <= 16'd0;
            r_cfg.holding_count <= 7'(REG_DEPTH);
        end else if (wr) begin
            unique case (idx)
                REG_SLAVE:     r_cfg.slave_address <= pwdata[7:0];
                REG_IN_BASE:   r_cfg.input_base    <= pwdata[15:0];
                REG_IN_CNT:    r_cfg.input_count   <= pwdata[6:0];
                REG_HOLD_BASE: r_cfg.holding_base  <= pwdata[15:0];
                REG_HOLD_CNT:  r_cfg.holding_count <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SLAVE:     prdata = {24'h0, r_cfg.slave_address};
            REG_IN_BASE:   prdata = {16'h0, r_cfg.input_base};
            REG_IN_CNT:    prdata = {25'h0, r_cfg.input_count};
            REG_HOLD_BASE: prdata = {16'h0, r_cfg.holding_base};
            REG_HOLD_CNT:  prdata = {25'h0, r_cfg.holding_count};
            default:       prdata = 32'h0;
        endcase
    end

endmodule

>>> rtl/mbrtu_front.sv
`timescale 1ns / 1ps
module mbrtu_front import mbrtu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mbrtu_in_if.sink   i_item,
    output t_item      o_head,
    output logic       o_head_valid,
    input  logic       i_pop
);

    t_item                 r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;
    t_item                 cls;
    logic                  push;

    always_comb begin
        cls.rx_byte = i_item.rx_byte;
        cls.last    = i_item.frame_last;
        cls.idx     = i_item.host_index;
        cls.value   = i_item.host_value;
        unique case (i_item.action)
            ACT_RX:      cls.op = OP_RX;
            ACT_PULL:    cls.op = OP_PULL;
            ACT_HOST_WR: cls.op = OP_HOST_WR;
            ACT_HOST_RD: cls.op = OP_HOST_RD;
            default:     cls.op = OP_RX;
        endcase
    end

    assign i_item.ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push         = i_item.valid & i_item.ready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(i_pop);
        end
    end

endmodule

>>> rtl/mbrtu_back.sv
`timescale 1ns / 1ps
module mbrtu_back import mbrtu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  t_item        i_head,
    input  logic         i_head_valid,
    output logic         o_pop,
    mbrtu_out_if.source  o_result
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_PULL_W = 14'h0002,
        S_HRD_W  = 14'h0004,
        S_FCRC   = 14'h0008,
        S_FCHK   = 14'h0010,
        S_EXC    = 14'h0020,
        S_ECHO   = 14'h0040,
        S_RHDR   = 14'h0080,
        S_RISS   = 14'h0100,
        S_RHI    = 14'h0200,
        S_RLO    = 14'h0400,
        S_W16    = 14'h0800,
        S_CRC0   = 14'h1000,
        S_CRC1   = 14'h2000
    } t_state;

    // storage
    logic [7:0]  m_fb [FRAME_BYTES];
    logic [7:0]  m_rb [RESP_BYTES];
    logic [15:0] m_ir [REG_DEPTH];
    logic [15:0] m_hr [REG_DEPTH];
    logic [REG_DEPTH-1:0] r_iv, r_hv;
    logic [7:0]  r_fb_q, r_rb_q;
    logic [15:0] r_ir_q, r_hr_q;
    logic        r_iv_q, r_hv_q;

    logic              fb_we, rb_we, ir_we, hr_we;
    logic [FB_AW-1:0]  fb_wa, fb_ra, rb_wa, rb_ra;
    logic [7:0]        fb_wd, rb_wd;
    logic [REG_AW-1:0] ir_wa, ir_ra, hr_wa, hr_ra;
    logic [15:0]       ir_wd, hr_wd;

    // control and working registers
    t_state      r_state, n_state;
    logic [8:0]  r_len, n_len;
    logic        r_ovf, n_ovf;
    logic [8:0]  r_n, n_n;
    logic [8:0]  r_i, n_i;
    logic        r_pv, n_pv;
    logic [8:0]  r_pi, n_pi;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_hdr [HDR_BYTES];
    logic [7:0]  n_hdr [HDR_BYTES];
    logic [7:0]  r_clo, n_clo, r_chi, n_chi;
    logic [8:0]  r_wp, n_wp;
    logic [6:0]  r_k, n_k;
    logic [REG_AW-1:0] r_map, n_map;
    logic [6:0]  r_word, n_word;
    logic [7:0]  r_exc, n_exc;
    logic [8:0]  r_rlen, n_rlen;
    logic [8:0]  r_rptr, n_rptr;
    logic        r_tl, n_tl;
    logic [7:0]  r_hi, n_hi;
    logic        r_isinp, n_isinp;
    logic        r_out_valid, n_out_valid;
    t_res        r_out, n_out;

    // datapath helpers
    logic        slot_free, len_inc, rx_ovf;
    logic [8:0]  rx_n;
    logic        crc_en, resp_wr;
    logic [7:0]  crc_b, resp_b;
    logic [7:0]  fn;
    logic [15:0] addr16, word16, base;
    logic [6:0]  in_cnt, hold_cnt, cnt;
    logic        is_inp;
    logic [16:0] diff;
    logic [17:0] span, wr_need;
    logic        span_bad, one_bad, rd_cnt_bad, wr_cnt_bad, addr_ok, crc_ok;
    logic [15:0] rd_val;
    logic [8:0]  w_end;
    logic [REG_AW-1:0] rd_idx;

    function automatic t_res status_res(input logic [2:0] st);
        t_res r;
        r = '0;
        r.frame_status = st;
        return r;
    endfunction

    assign slot_free = !r_out_valid || o_result.ready;
    assign len_inc   = (r_len < 9'(FRAME_BYTES));
    assign rx_n      = r_len + 9'(len_inc);
    assign rx_ovf    = r_ovf | ~len_inc;

    assign fn       = r_hdr[1];
    assign addr16   = {r_hdr[2], r_hdr[3]};
    assign word16   = {r_hdr[4], r_hdr[5]};
    assign in_cnt   = (i_cfg.input_count > 7'(REG_DEPTH)) ? 7'(REG_DEPTH)
                                                           : i_cfg.input_count;
    assign hold_cnt = (i_cfg.holding_count > 7'(REG_DEPTH)) ? 7'(REG_DEPTH)
                                                             : i_cfg.holding_count;
    assign is_inp   = (fn == FN_RD_INPUT);
    assign base     = is_inp ? i_cfg.input_base : i_cfg.holding_base;
    assign cnt      = is_inp ? in_cnt : hold_cnt;
    assign diff     = {1'b0, addr16} - {1'b0, base};
    assign span     = {2'b00, diff[15:0]} + {2'b00, word16};
    assign span_bad = diff[16] || (span > {11'd0, cnt});
    assign one_bad  = diff[16] || (diff[15:0] >= {9'd0, cnt});
    assign rd_cnt_bad = (word16 == 16'd0) || (word16 > 16'(MAX_READ));
    assign wr_need    = 18'd9 + {1'b0, word16, 1'b0};
    assign wr_cnt_bad = (word16 == 16'd0) || (word16 > 16'(MAX_WRITE))
                        || ({9'd0, r_n} < wr_need);
    assign addr_ok  = (r_hdr[0] == i_cfg.slave_address) || (r_hdr[0] == BCAST_ADDR);
    assign crc_ok   = (r_clo == r_crc[7:0]) && (r_chi == r_crc[15:8]);
    assign w_end    = 9'd7 + {1'b0, r_word, 1'b0};
    assign rd_idx   = r_map + r_k[REG_AW-1:0];
    assign rd_val   = r_isinp ? (r_iv_q ? r_ir_q : 16'h0) : (r_hv_q ? r_hr_q : 16'h0);

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_i     = r_i;
        n_pv    = r_pv;
        n_pi    = r_pi;
        n_crc   = r_crc;
        n_hdr   = r_hdr;
        n_clo   = r_clo;
        n_chi   = r_chi;
        n_wp    = r_wp;
        n_k     = r_k;
        n_map   = r_map;
        n_word  = r_word;
        n_exc   = r_exc;
        n_rlen  = r_rlen;
        n_rptr  = r_rptr;
        n_tl    = r_tl;
        n_hi    = r_hi;
        n_isinp = r_isinp;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out   = r_out;
        o_pop   = 1'b0;
        fb_we = 1'b0; fb_wa = r_len[FB_AW-1:0]; fb_wd = i_head.rx_byte;
        fb_ra = r_i[FB_AW-1:0];
        rb_we = 1'b0; rb_wa = r_wp[FB_AW-1:0]; rb_wd = '0;
        rb_ra = r_rptr[FB_AW-1:0];
        ir_we = 1'b0; ir_wa = i_head.idx; ir_wd = i_head.value;
        ir_ra = rd_idx;
        hr_we = 1'b0; hr_wa = r_map; hr_wd = word16;
        hr_ra = rd_idx;
        crc_en  = 1'b0;
        crc_b   = r_fb_q;
        resp_wr = 1'b0;
        resp_b  = r_hdr[0];

        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid && slot_free) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        OP_RX: begin
                            fb_we = len_inc;
                            n_len = rx_n;
                            n_ovf = rx_ovf;
                            if (i_head.last) begin
                                n_len = '0;
                                n_ovf = 1'b0;
                                n_n   = rx_n;
                                if (rx_ovf || rx_n < 9'(MIN_FRAME)) begin
                                    n_out_valid = 1'b1;
                                    n_out       = status_res(ST_LEN);
                                end else begin
                                    n_state = S_FCRC;
                                    n_i     = '0;
                                    n_pv    = 1'b0;
                                    n_crc   = CRC_INIT;
                                end
                            end else begin
                                n_out_valid = 1'b1;
                                n_out       = status_res(ST_NONE);
                            end
                        end
                        OP_PULL: begin
                            if (r_rptr < r_rlen) begin
                                n_tl    = (r_rptr + 9'd1 == r_rlen);
                                n_rptr  = r_rptr + 9'd1;
                                n_state = S_PULL_W;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out       = status_res(ST_NONE);
                            end
                        end
                        OP_HOST_WR: begin
                            ir_we       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = status_res(ST_NONE);
                        end
                        OP_HOST_RD: begin
                            hr_ra   = i_head.idx;
                            n_state = S_HRD_W;
                        end
                        default: ;
                    endcase
                end
            end
            S_PULL_W: begin
                n_out_valid      = 1'b1;
                n_out            = status_res(ST_NONE);
                n_out.tx_valid   = 1'b1;
                n_out.tx_byte    = r_rb_q;
                n_out.tx_last    = r_tl;
                n_state          = S_IDLE;
            end
            S_HRD_W: begin
                n_out_valid     = 1'b1;
                n_out           = status_res(ST_NONE);
                n_out.host_data = r_hv_q ? r_hr_q : 16'h0;
                n_state         = S_IDLE;
            end
            S_FCRC: begin
                if (r_i < r_n) begin
                    n_i  = r_i + 9'd1;
                    n_pv = 1'b1;
                    n_pi = r_i;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_pi < r_n - 9'd2) begin
                        crc_en = 1'b1;
                    end
                    if (r_pi < 9'(HDR_BYTES)) begin
                        n_hdr[r_pi[2:0]] = r_fb_q;
                    end
                    if (r_pi == r_n - 9'd2) begin
                        n_clo = r_fb_q;
                    end
                    if (r_pi == r_n - 9'd1) begin
                        n_chi   = r_fb_q;
                        n_state = S_FCHK;
                    end
                end
            end
            S_FCHK: begin
                n_wp    = '0;
                n_crc   = CRC_INIT;
                n_isinp = is_inp;
                n_map   = diff[REG_AW-1:0];
                n_word  = word16[6:0];
                n_k     = '0;
                n_i     = 9'd7;
                n_pv    = 1'b0;
                n_state = S_EXC;
                if (!addr_ok) begin
                    n_out_valid = 1'b1;
                    n_out       = status_res(ST_OTHER);
                    n_state     = S_IDLE;
                end else if (!crc_ok) begin
                    n_out_valid = 1'b1;
                    n_out       = status_res(ST_CRC);
                    n_state     = S_IDLE;
                end else if (fn == FN_RD_HOLD || fn == FN_RD_INPUT) begin
                    if (rd_cnt_bad) begin
                        n_exc = EXC_VALUE;
                    end else if (span_bad) begin
                        n_exc = EXC_ADDR;
                    end else begin
                        n_state = S_RHDR;
                    end
                end else if (fn == FN_WR_SINGLE) begin
                    if (one_bad) begin
                        n_exc = EXC_ADDR;
                    end else begin
                        hr_we   = 1'b1;
                        hr_wa   = diff[REG_AW-1:0];
                        n_state = S_ECHO;
                    end
                end else if (fn == FN_WR_MULTI) begin
                    if (wr_cnt_bad) begin
                        n_exc = EXC_VALUE;
                    end else if (span_bad) begin
                        n_exc = EXC_ADDR;
                    end else begin
                        n_state = S_W16;
                    end
                end else begin
                    n_exc = EXC_FUNC;
                end
            end
            S_EXC: begin
                resp_wr = 1'b1;
                case (r_wp[1:0])
                    2'd0:    resp_b = r_hdr[0];
                    2'd1:    resp_b = r_hdr[1] + EXC_FLAG;
                    default: resp_b = r_exc;
                endcase
                if (r_wp == 9'd2) begin
                    n_state = S_CRC0;
                end
            end
            S_ECHO: begin
                resp_wr = 1'b1;
                resp_b  = r_hdr[r_wp[2:0]];
                if (r_wp == 9'(HDR_BYTES - 1)) begin
                    n_state = S_CRC0;
                end
            end
            S_RHDR: begin
                resp_wr = 1'b1;
                case (r_wp[1:0])
                    2'd0:    resp_b = r_hdr[0];
                    2'd1:    resp_b = r_hdr[1];
                    default: resp_b = {r_word, 1'b0};
                endcase
                if (r_wp == 9'd2) begin
                    n_state = S_RISS;
                end
            end
            S_RISS: begin
                n_state = S_RHI;
            end
            S_RHI: begin
                resp_wr = 1'b1;
                resp_b  = rd_val[15:8];
                n_state = S_RLO;
            end
            S_RLO: begin
                resp_wr = 1'b1;
                resp_b  = rd_val[7:0];
                n_k     = r_k + 7'd1;
                if (r_k + 7'd1 < r_word) begin
                    ir_ra   = rd_idx + 1'b1;
                    hr_ra   = rd_idx + 1'b1;
                    n_state = S_RHI;
                end else begin
                    n_state = S_CRC0;
                end
            end
            S_W16: begin
                if (r_i < w_end) begin
                    n_i  = r_i + 9'd1;
                    n_pv = 1'b1;
                    n_pi = r_i;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_pi[0]) begin
                        n_hi = r_fb_q;
                    end else begin
                        hr_we = 1'b1;
                        hr_wa = rd_idx;
                        hr_wd = {r_hi, r_fb_q};
                        n_k   = r_k + 7'd1;
                        if (r_k + 7'd1 == r_word) begin
                            n_state = S_ECHO;
                        end
                    end
                end
            end
            S_CRC0: begin
                rb_we   = 1'b1;
                rb_wd   = r_crc[7:0];
                n_wp    = r_wp + 9'd1;
                n_state = S_CRC1;
            end
            S_CRC1: begin
                rb_we       = 1'b1;
                rb_wd       = r_crc[15:8];
                n_rlen      = r_wp + 9'd1;
                n_rptr      = '0;
                n_out_valid = 1'b1;
                n_out       = status_res(ST_REPLY);
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (resp_wr) begin
            rb_we  = 1'b1;
            rb_wd  = resp_b;
            n_wp   = r_wp + 9'd1;
            crc_en = 1'b1;
            crc_b  = resp_b;
        end
        if (crc_en) begin
            n_crc = crc_byte(r_crc, crc_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            m_fb[fb_wa] <= fb_wd;
        end
        r_fb_q <= m_fb[fb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rb_we) begin
            m_rb[rb_wa] <= rb_wd;
        end
        r_rb_q <= m_rb[rb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ir_we) begin
            m_ir[ir_wa] <= ir_wd;
        end
        r_ir_q <= m_ir[ir_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hr_we) begin
            m_hr[hr_wa] <= hr_wd;
        end
        r_hr_q <= m_hr[hr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= '0;
            r_hv <= '0;
        end else begin
            if (ir_we) begin
                r_iv[ir_wa] <= 1'b1;
            end
            if (hr_we) begin
                r_hv[hr_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_iv_q  <= r_iv[ir_ra];
        r_hv_q  <= r_hv[hr_ra];
        r_n     <= n_n;
        r_i     <= n_i;
        r_pi    <= n_pi;
        r_crc   <= n_crc;
        r_hdr   <= n_hdr;
        r_clo   <= n_clo;
        r_chi   <= n_chi;
        r_wp    <= n_wp;
        r_k     <= n_k;
        r_map   <= n_map;
        r_word  <= n_word;
        r_exc   <= n_exc;
        r_tl    <= n_tl;
        r_hi    <= n_hi;
        r_isinp <= n_isinp;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_pv        <= 1'b0;
            r_rlen      <= '0;
            r_rptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_pv        <= n_pv;
            r_rlen      <= n_rlen;
            r_rptr      <= n_rptr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.tx_valid     = r_out.tx_valid;
    assign o_result.tx_byte      = r_out.tx_byte;
    assign o_result.tx_last      = r_out.tx_last;
    assign o_result.host_data    = r_out.host_data;
    assign o_result.frame_status = r_out.frame_status;

endmodule

>>> rtl/modbus_rtu_slave_register_server_core.sv
`timescale 1ns / 1ps
// Non-final bytes, pulls and host accesses each give one result; items wait in a 2-deep queue.
// A frame end that passes the length check first walks the n buffered bytes for the CRC, then
// handles each register read (or each register written for function 16) and the reply.
// The back end takes one item at a time and pops the next only when its output slot is free.
// Reset (sync, active low): config to defaults, counts and pointers cleared, register file valid
// bits cleared at once; frame and response buffers are not cleared.
module modbus_rtu_slave_register_server_core import mbrtu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbrtu_in_if.sink          i_item,
    mbrtu_out_if.source       o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg  cfg;
    t_item head;
    logic  head_valid;
    logic  pop;

    mbrtu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbrtu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    mbrtu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

>>> rtl/mbrtu_checker.sv
`timescale 1ns / 1ps
`include "modbus_rtu_slave_register_server_core_macros.svh"
module mbrtu_checker import mbrtu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_tx_valid,
    input logic [7:0]  i_tx_byte,
    input logic        i_tx_last,
    input logic [15:0] i_host_data,
    input logic [2:0]  i_frame_status
);

    `MBRTU_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `MBRTU_ASSERT_IMP(a_last, i_clk, i_rst_n, i_out_valid && i_tx_last, i_tx_valid, "tx_last without tx_valid")
    `MBRTU_ASSERT_IMP(a_idle_tx, i_clk, i_rst_n, i_out_valid && !i_tx_valid, i_tx_byte == 8'h00 && !i_tx_last, "stray tx byte")
    `MBRTU_ASSERT_IMP(a_frame, i_clk, i_rst_n, i_out_valid && i_frame_status != ST_NONE, !i_tx_valid && i_host_data == 16'h0 && i_frame_status <= ST_LEN, "bad frame result")

endmodule

bind modbus_rtu_slave_register_server_core mbrtu_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_tx_valid     (o_result.tx_valid),
    .i_tx_byte      (o_result.tx_byte),
    .i_tx_last      (o_result.tx_last),
    .i_host_data    (o_result.host_data),
    .i_frame_status (o_result.frame_status)
);
